// File: src/ifr_pkg.sv
// Shared constants, types and helpers for the frequency response block.
`timescale 1ns / 1ps
package ifr_pkg;

   localparam int MAX_ORDER   = 8;
   localparam int COEF_WIDTH  = 16;
   localparam int PHASE_WIDTH = 16;

   localparam int IDX_W      = $clog2(MAX_ORDER + 1);
   localparam int ORD_W      = 4;
   localparam int ACC_W      = 32;
   localparam int ACC_FRAC   = 20;
   localparam int TRIG_W     = 26;
   localparam int TRIG_FRAC  = 24;
   localparam int COEF_FRAC  = COEF_WIDTH - 3;
   localparam int COEF_SHIFT = ACC_FRAC - COEF_FRAC;
   localparam int PROD_W     = 64;
   localparam int OUT_W      = 32;
   localparam int TURN_W     = 32;

   // quarter-wave sine polynomial, Q1.30
   localparam logic [30:0] K_C1    = 31'd1686629713;
   localparam logic [30:0] K_C3    = 31'd693598669;
   localparam logic [30:0] K_C5    = 31'd85569306;
   localparam logic [30:0] K_C7    = 31'd5026996;
   localparam logic [30:0] K_C9    = 31'd172272;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

   typedef enum logic [1:0] {
      OP_WR_NUM = 2'd0,
      OP_WR_DEN = 2'd1,
      OP_EVAL   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_DEN_ZERO = 2'd1,
      STAT_SAT      = 2'd2
   } status_type;

   typedef logic signed [ACC_W-1:0]      acc_type;
   typedef logic signed [TRIG_W-1:0]     trig_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [COEF_WIDTH-1:0] coef_type;

   typedef struct packed {
      logic done;
      logic sat;
   } div_stat_type;

   function automatic acc_type coef_to_acc(coef_type v);
      acc_type w;
      w = ACC_W'(v);
      return w <<< COEF_SHIFT;
   endfunction

endpackage

// File: src/ifr_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface ifr_req_if import ifr_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [1:0]                    operation;
   logic [3:0]                    coef_index;
   logic signed [COEF_WIDTH-1:0]  coef_value;
   logic [PHASE_WIDTH-1:0]        phase;
   logic                          last_point;

   modport source(output valid, operation, coef_index, coef_value, phase, last_point,
                  input ready);
   modport sink(input valid, operation, coef_index, coef_value, phase, last_point,
                output ready);
endinterface

interface ifr_rsp_if import ifr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [OUT_W-1:0]  real_part;
   logic signed [OUT_W-1:0]  imag_part;
   logic [1:0]               status;
   logic                     is_last;

   modport source(output valid, real_part, imag_part, status, is_last, input ready);
   modport sink(input valid, real_part, imag_part, status, is_last, output ready);
endinterface

// File: src/ifr_coef_mem.sv
// Numerator and denominator coefficient memories with registered read.
`timescale 1ns / 1ps
module ifr_coef_mem import ifr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic             wr_den,
   input  logic [IDX_W-1:0] wr_addr,
   input  coef_type         wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output coef_type         rd_num,
   output coef_type         rd_den
);
   coef_type             num_mem [0:MAX_ORDER];
   coef_type             den_mem [0:MAX_ORDER];
   logic [MAX_ORDER:0]   num_vld_ff;
   logic [MAX_ORDER:0]   den_vld_ff;
   coef_type             rd_num_ff;
   coef_type             rd_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_vld_ff <= '0;
         den_vld_ff <= '0;
      end else if (wr_en) begin
         if (wr_den) den_vld_ff[wr_addr] <= 1'b1;
         else        num_vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (wr_den) den_mem[wr_addr] <= wr_data;
         else        num_mem[wr_addr] <= wr_data;
      end
      // entry never written reads as zero
      rd_num_ff <= num_vld_ff[rd_addr] ? num_mem[rd_addr] : '0;
      rd_den_ff <= den_vld_ff[rd_addr] ? den_mem[rd_addr] : '0;
   end

   assign rd_num = rd_num_ff;
   assign rd_den = rd_den_ff;
endmodule

// File: src/ifr_sincos.sv
// Sequential sine/cosine unit on one shared multiplier.
`timescale 1ns / 1ps
module ifr_sincos import ifr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [PHASE_WIDTH-1:0] phase,
   output logic                   done,
   output trig_type               sin_q,
   output trig_type               cos_q
);
   logic              busy_ff, busy_in;
   logic              arg_ff, arg_in;
   logic              mulph_ff, mulph_in;
   logic [2:0]        step_ff, step_in;
   logic              done_ff, done_in;
   logic [1:0]        quad_ff, quad_in;
   logic [29:0]       xs_ff, xs_in;
   logic [30:0]       x_ff, x_in;
   logic [30:0]       x2_ff, x2_in;
   logic [30:0]       t_ff, t_in;
   logic [61:0]       prod_ff, prod_in;
   logic [24:0]       s_ff, s_in;
   trig_type          sin_ff, sin_in, cos_ff, cos_in;
   logic [TURN_W-1:0] turn;
   logic [30:0]       op_a, op_b;
   logic [31:0]       sh;
   logic [31:0]       clamp;
   logic [24:0]       rnd;
   trig_type          sv, cv;

   always_comb begin
      turn = {phase, (TURN_W - PHASE_WIDTH)'(0)};
      sh   = prod_ff[61:30];
      clamp = (sh > 32'(ONE_Q30)) ? 32'(ONE_Q30) : sh;
      rnd  = 25'((clamp + 32'd32) >> 6);
      op_a = (step_ff == 3'd0 || step_ff == 3'd5) ? x_ff : x2_ff;
      case (step_ff)
         3'd0:    op_b = x_ff;
         3'd1:    op_b = K_C9;
         default: op_b = t_ff;
      endcase
      sv = TRIG_W'({1'b0, s_ff});
      cv = TRIG_W'({1'b0, rnd});

      busy_in  = busy_ff;
      arg_in   = arg_ff;
      mulph_in = mulph_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      quad_in  = quad_ff;
      xs_in    = xs_ff;
      x_in     = x_ff;
      x2_in    = x2_ff;
      t_in     = t_ff;
      prod_in  = prod_ff;
      s_in     = s_ff;
      sin_in   = sin_ff;
      cos_in   = cos_ff;

      if (start) begin
         busy_in  = 1'b1;
         arg_in   = 1'b0;
         mulph_in = 1'b0;
         step_in  = 3'd0;
         quad_in  = turn[31:30];
         xs_in    = turn[29:0];
         x_in     = {1'b0, turn[29:0]};
      end else if (busy_ff && !mulph_ff) begin
         prod_in  = op_a * op_b;
         mulph_in = 1'b1;
      end else if (busy_ff) begin
         mulph_in = 1'b0;
         step_in  = step_ff + 3'd1;
         case (step_ff)
            3'd0: x2_in = sh[30:0];
            3'd1: t_in  = 31'(32'(K_C7) - sh);
            3'd2: t_in  = 31'(32'(K_C5) - sh);
            3'd3: t_in  = 31'(32'(K_C3) - sh);
            3'd4: t_in  = 31'(32'(K_C1) - sh);
            default: begin
               step_in = 3'd0;
               if (!arg_ff) begin
                  // sine done, start on the complement angle
                  s_in   = rnd;
                  arg_in = 1'b1;
                  x_in   = ONE_Q30 - {1'b0, xs_ff};
               end else begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
                  case (quad_ff)
                     2'd0:    begin sin_in = sv;  cos_in = cv;  end
                     2'd1:    begin sin_in = cv;  cos_in = -sv; end
                     2'd2:    begin sin_in = -sv; cos_in = -cv; end
                     default: begin sin_in = -cv; cos_in = sv;  end
                  endcase
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         mulph_ff <= 1'b0;
         done_ff  <= 1'b0;
         step_ff  <= 3'd0;
         arg_ff   <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         mulph_ff <= mulph_in;
         done_ff  <= done_in;
         step_ff  <= step_in;
         arg_ff   <= arg_in;
      end
   end

   always_ff @(posedge clock) begin
      quad_ff <= quad_in;
      xs_ff   <= xs_in;
      x_ff    <= x_in;
      x2_ff   <= x2_in;
      t_ff    <= t_in;
      prod_ff <= prod_in;
      s_ff    <= s_in;
      sin_ff  <= sin_in;
      cos_ff  <= cos_in;
   end

   assign done  = done_ff;
   assign sin_q = sin_ff;
   assign cos_q = cos_ff;
endmodule

// File: src/ifr_div.sv
// Restoring divider: signed numerator over positive denominator to Q8.23.
`timescale 1ns / 1ps
module ifr_div import ifr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  prod_type                num,
   input  logic [PROD_W-1:0]       den,
   output logic signed [OUT_W-1:0] quo,
   output div_stat_type            stat
);
   localparam logic signed [OUT_W-1:0] Q_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] Q_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   logic              busy_ff, rnd_ff, done_ff, neg_ff, sat_ff;
   logic [5:0]        cnt_ff;
   logic [PROD_W-1:0] p_ff, den_ff;
   logic [31:0]       bits_ff, q_ff;
   logic signed [OUT_W-1:0] quo_ff;
   logic [PROD_W-1:0] mag;
   logic              ovf;
   logic [PROD_W-1:0] trial;
   logic              ge;
   logic [31:0]       qr;

   always_comb begin
      mag   = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
      ovf   = {8'd0, mag} >= {den, 8'd0};
      trial = {p_ff[PROD_W-2:0], bits_ff[31]};
      ge    = trial >= den_ff;
      qr    = 32'(({1'b0, q_ff} + 33'd1) >> 1);
   end

   // an overflow keeps its clamped value but runs the full length, so both
   // parts of a response finish in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rnd_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         rnd_ff  <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd32;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               rnd_ff  <= 1'b1;
            end
         end else if (rnd_ff) begin
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff  <= num[PROD_W-1];
         den_ff  <= den;
         p_ff    <= mag >> 8;
         bits_ff <= {mag[7:0], 24'd0};
         q_ff    <= '0;
         sat_ff  <= ovf;
         quo_ff  <= num[PROD_W-1] ? Q_MIN : Q_MAX;
      end else if (busy_ff) begin
         p_ff    <= ge ? trial - den_ff : trial;
         bits_ff <= {bits_ff[30:0], 1'b0};
         q_ff    <= {q_ff[30:0], ge};
      end else if (rnd_ff && !sat_ff) begin
         // round half away from zero, clamp to the Q8.23 range
         if (!neg_ff) begin
            sat_ff <= qr[31];
            quo_ff <= qr[31] ? Q_MAX : qr;
         end else begin
            sat_ff <= qr > 32'h8000_0000;
            quo_ff <= (qr > 32'h8000_0000) ? Q_MIN : -qr;
         end
      end
   end

   assign quo       = quo_ff;
   assign stat.done = done_ff;
   assign stat.sat  = sat_ff;
endmodule

// File: src/iir_frequency_response.sv
// Top level: frequency response of a rational filter at one phase point.
`timescale 1ns / 1ps
// An evaluate beat passes through the sine/cosine sequencer, one Horner step per order
//   on the shared complex multiplier (states S_MULN, S_MULD, S_ADDD) and, unless the
//   denominator is zero, the bit-serial dividers. No request is taken while an evaluate
//   is in flight; coefficient writes are accepted back to back while idle.
// Reset (synchronous, active high) clears the order, the coefficient valid bits
//   (all coefficients read as zero) and all handshake state.
module iir_frequency_response import ifr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   ifr_req_if.sink          req_if,
   ifr_rsp_if.source        rsp_if,
   input  logic             csr_we,
   input  logic [ORD_W-1:0] csr_wdata
);
   // One-hot sequencer states
   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_TRIG  = 12'b0000_0000_0010,
      S_HINIT = 12'b0000_0000_0100,
      S_MULN  = 12'b0000_0000_1000,
      S_MULD  = 12'b0000_0001_0000,
      S_ADDD  = 12'b0000_0010_0000,
      S_PROD1 = 12'b0000_0100_0000,
      S_PROD2 = 12'b0000_1000_0000,
      S_PROD3 = 12'b0001_0000_0000,
      S_DCHK  = 12'b0010_0000_0000,
      S_DIV   = 12'b0100_0000_0000,
      S_FIN   = 12'b1000_0000_0000
   } state_type;

   localparam prod_type HRND = PROD_W'(1) <<< (TRIG_FRAC - 1);

   state_type          state_ff, state_in;
   logic [ORD_W-1:0]   order_ff;
   logic [IDX_W-1:0]   ord;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic               last_ff;
   trig_type           zr_ff, zi_ff;
   acc_type            nr_ff, ni_ff, dr_ff, di_ff;
   prod_type           prod_ff [4];
   acc_type            op_a [4];
   acc_type            op_b [4];
   prod_type           num_re_ff, num_im_ff;
   logic [PROD_W-1:0]  den_ff;
   logic               denz_ff;

   logic               rsp_vld_ff;
   logic signed [OUT_W-1:0] rsp_re_ff, rsp_im_ff;
   status_type         rsp_stat_ff;
   logic               rsp_last_ff;

   logic               req_acc;
   logic               wr_en;
   logic               eval_go;
   coef_type           rd_num, rd_den;
   logic               trig_done;
   trig_type           sin_q, cos_q;
   prod_type           hsum_re, hsum_im;
   acc_type            h_re, h_im;
   logic               div_go;
   logic signed [OUT_W-1:0] q_re, q_im;
   div_stat_type       st_re, st_im;
   logic               out_free;

   // ready only while no evaluate is in flight
   assign req_if.ready = (state_ff == S_IDLE);
   assign req_acc      = req_if.valid && req_if.ready;
   assign wr_en        = req_acc && (req_if.operation == OP_WR_NUM ||
                                     req_if.operation == OP_WR_DEN) &&
                         (req_if.coef_index <= 4'(MAX_ORDER));
   assign eval_go      = req_acc && (req_if.operation == OP_EVAL);
   assign ord          = (order_ff > ORD_W'(MAX_ORDER)) ? IDX_W'(MAX_ORDER)
                                                          : IDX_W'(order_ff);
   assign out_free     = !rsp_vld_ff || rsp_if.ready;
   assign div_go       = (state_ff == S_DCHK) && (den_ff != '0);

   ifr_coef_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_den  (req_if.operation == OP_WR_DEN),
      .wr_addr (IDX_W'(req_if.coef_index)),
      .wr_data (req_if.coef_value),
      .rd_addr (k_ff),
      .rd_num  (rd_num),
      .rd_den  (rd_den)
   );

   ifr_sincos u_trig (
      .clock (clock),
      .reset (reset),
      .start (eval_go),
      .phase (req_if.phase),
      .done  (trig_done),
      .sin_q (sin_q),
      .cos_q (cos_q)
   );

   ifr_div u_div_re (
      .clock (clock),
      .reset (reset),
      .start (div_go),
      .num   (num_re_ff),
      .den   (den_ff),
      .quo   (q_re),
      .stat  (st_re)
   );

   ifr_div u_div_im (
      .clock (clock),
      .reset (reset),
      .start (div_go),
      .num   (num_im_ff),
      .den   (den_ff),
      .quo   (q_im),
      .stat  (st_im)
   );

   // Shared four-lane multiplier: Horner products with z, then the
   // cross products N*conj(D) and |D|^2.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         op_a[i] = '0;
         op_b[i] = '0;
      end
      unique case (state_ff)
         S_MULN: begin
            op_a[0] = nr_ff; op_b[0] = ACC_W'(zr_ff);
            op_a[1] = ni_ff; op_b[1] = ACC_W'(zi_ff);
            op_a[2] = nr_ff; op_b[2] = ACC_W'(zi_ff);
            op_a[3] = ni_ff; op_b[3] = ACC_W'(zr_ff);
         end
         S_MULD: begin
            op_a[0] = dr_ff; op_b[0] = ACC_W'(zr_ff);
            op_a[1] = di_ff; op_b[1] = ACC_W'(zi_ff);
            op_a[2] = dr_ff; op_b[2] = ACC_W'(zi_ff);
            op_a[3] = di_ff; op_b[3] = ACC_W'(zr_ff);
         end
         S_PROD1: begin
            op_a[0] = nr_ff; op_b[0] = dr_ff;
            op_a[1] = ni_ff; op_b[1] = di_ff;
            op_a[2] = ni_ff; op_b[2] = dr_ff;
            op_a[3] = nr_ff; op_b[3] = di_ff;
         end
         S_PROD2: begin
            op_a[0] = dr_ff; op_b[0] = dr_ff;
            op_a[1] = di_ff; op_b[1] = di_ff;
         end
         default: ;
      endcase
   end

   // Round each Horner product from Q.44 to Q.20, half up
   always_comb begin
      hsum_re = prod_ff[0] - prod_ff[1] + HRND;
      hsum_im = prod_ff[2] + prod_ff[3] + HRND;
      h_re    = ACC_W'(hsum_re >>> TRIG_FRAC);
      h_im    = ACC_W'(hsum_im >>> TRIG_FRAC);
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      unique case (state_ff)
         S_IDLE:  if (eval_go) begin
            state_in = S_TRIG;
            k_in     = ord;
         end
         S_TRIG:  if (trig_done) state_in = S_HINIT;
         S_HINIT: begin
            if (k_ff == '0) state_in = S_PROD1;
            else begin
               state_in = S_MULN;
               k_in     = k_ff - IDX_W'(1);
            end
         end
         S_MULN:  state_in = S_MULD;
         S_MULD:  state_in = S_ADDD;
         S_ADDD: begin
            if (k_ff == '0) state_in = S_PROD1;
            else begin
               state_in = S_MULN;
               k_in     = k_ff - IDX_W'(1);
            end
         end
         S_PROD1: state_in = S_PROD2;
         S_PROD2: state_in = S_PROD3;
         S_PROD3: state_in = S_DCHK;
         S_DCHK:  state_in = (den_ff == '0) ? S_FIN : S_DIV;
         S_DIV:   if (st_re.done) state_in = S_FIN;
         S_FIN:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         order_ff   <= '0;
         rsp_vld_ff <= 1'b0;
         k_ff       <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         if (csr_we) order_ff <= csr_wdata;
         // hold the response until taken, load a new one at the end of an evaluate
         if (state_ff == S_FIN && out_free) rsp_vld_ff <= 1'b1;
         else if (rsp_if.ready)             rsp_vld_ff <= 1'b0;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) prod_ff[i] <= op_a[i] * op_b[i];
      if (eval_go) last_ff <= req_if.last_point;
      if (state_ff == S_TRIG && trig_done) begin
         zr_ff <= cos_q;
         zi_ff <= -sin_q;
      end
      if (state_ff == S_HINIT) begin
         nr_ff <= coef_to_acc(rd_num);
         ni_ff <= '0;
         dr_ff <= coef_to_acc(rd_den);
         di_ff <= '0;
      end
      if (state_ff == S_MULD) begin
         nr_ff <= h_re + coef_to_acc(rd_num);
         ni_ff <= h_im;
      end
      if (state_ff == S_ADDD) begin
         dr_ff <= h_re + coef_to_acc(rd_den);
         di_ff <= h_im;
      end
      if (state_ff == S_PROD2) begin
         num_re_ff <= prod_ff[0] + prod_ff[1];
         num_im_ff <= prod_ff[2] - prod_ff[3];
      end
      if (state_ff == S_PROD3) den_ff <= PROD_W'(prod_ff[0] + prod_ff[1]);
      if (state_ff == S_DCHK)  denz_ff <= (den_ff == '0);
      if (state_ff == S_FIN && out_free) begin
         rsp_last_ff <= last_ff;
         if (denz_ff) begin
            rsp_re_ff   <= '0;
            rsp_im_ff   <= '0;
            rsp_stat_ff <= STAT_DEN_ZERO;
         end else begin
            rsp_re_ff   <= q_re;
            rsp_im_ff   <= q_im;
            rsp_stat_ff <= (st_re.sat || st_im.sat) ? STAT_SAT : STAT_OK;
         end
      end
   end

   assign rsp_if.valid     = rsp_vld_ff;
   assign rsp_if.real_part = rsp_re_ff;
   assign rsp_if.imag_part = rsp_im_ff;
   assign rsp_if.status    = rsp_stat_ff;
   assign rsp_if.is_last   = rsp_last_ff;
endmodule

// File: src/ifr_checker.sv
// Port-level checks for the frequency response block, with its bind.
`timescale 1ns / 1ps
module ifr_checker import ifr_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [OUT_W-1:0] rsp_real,
   input logic signed [OUT_W-1:0] rsp_imag,
   input logic [1:0]              rsp_status
);
   localparam logic signed [OUT_W-1:0] Q_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] Q_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped before taken");

   a_den_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_DEN_ZERO |-> rsp_real == '0 && rsp_imag == '0)
      else $error("zero denominator with nonzero value");

   a_stat_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STAT_OK || rsp_status == STAT_DEN_ZERO ||
                    rsp_status == STAT_SAT)
      else $error("unknown status code");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_SAT |->
         rsp_real == Q_MAX || rsp_real == Q_MIN || rsp_imag == Q_MAX || rsp_imag == Q_MIN)
      else $error("saturated status without a clamped part");
endmodule

bind iir_frequency_response ifr_checker u_ifr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_real   (rsp_if.real_part),
   .rsp_imag   (rsp_if.imag_part),
   .rsp_status (rsp_if.status)
);

// File: tb/iir_frequency_response_chk.sv
// Checker: predicts the filter response for each accepted evaluate beat and compares.
`timescale 1ns / 1ps
module iir_frequency_response_chk import ifr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   ifr_req_if               req,
   ifr_rsp_if               rsp,
   input  logic             csr_we,
   input  logic [ORD_W-1:0] csr_wdata,
   output int               errors,
   output int               pending
);

   typedef struct {
      logic signed [OUT_W-1:0] re;
      logic signed [OUT_W-1:0] im;
      status_type              st;
      logic                    last;
   } response_type;

   response_type     response_q[$];
   longint           num_store[MAX_ORDER+1];
   longint           den_store[MAX_ORDER+1];
   logic [ORD_W-1:0] order;

   assign pending = response_q.size();

   function automatic longint round_q(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint coef_acc(longint v);
      return v <<< COEF_SHIFT;
   endfunction

   // quarter-wave sine, Q1.30 in and out
   function automatic bit [63:0] quarter_sine(bit [63:0] x);
      bit [63:0] x2, t;
      x2 = (x * x) >> 30;
      t = 64'(K_C9);
      t = 64'(K_C7) - ((x2 * t) >> 30);
      t = 64'(K_C5) - ((x2 * t) >> 30);
      t = 64'(K_C3) - ((x2 * t) >> 30);
      t = 64'(K_C1) - ((x2 * t) >> 30);
      t = (x * t) >> 30;
      return (t > 64'(ONE_Q30)) ? 64'(ONE_Q30) : t;
   endfunction

   function automatic void horner_eval(input bit use_den, input int ord,
                                       input longint zr, input longint zi,
                                       output longint out_r, output longint out_i);
      longint ar, ai, pr, pim, ck;
      ar = coef_acc(use_den ? den_store[ord] : num_store[ord]);
      ai = 0;
      for (int k = ord - 1; k >= 0; k--) begin
         ck = coef_acc(use_den ? den_store[k] : num_store[k]);
         pr = round_q(ar * zr - ai * zi, TRIG_FRAC) + ck;
         pim = round_q(ar * zi + ai * zr, TRIG_FRAC);
         ar = pr;
         ai = pim;
      end
      out_r = ar;
      out_i = ai;
   endfunction

   // long division to 24 fraction bits, round half away from zero to 23
   function automatic bit divide_q23(input longint num, input bit [63:0] den,
                                     output logic signed [OUT_W-1:0] res);
      bit        neg;
      bit [63:0] mag, q, r;
      neg = num < 0;
      mag = neg ? 64'(-num) : 64'(num);
      q = mag / den;
      r = mag % den;
      if (q >= 256) begin
         res = neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
         return 1;
      end
      for (int i = 0; i < 24; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q[0] = 1'b1;
         end
      end
      q = (q + 1) >> 1;
      if (!neg) begin
         if (q > 64'h7fff_ffff) begin
            res = 32'sh7fff_ffff;
            return 1;
         end
         res = q[31:0];
      end else begin
         if (q > 64'h8000_0000) begin
            res = 32'sh8000_0000;
            return 1;
         end
         res = -q[31:0];
      end
      return 0;
   endfunction

   function automatic response_type predict_response(logic [PHASE_WIDTH-1:0] ph,
                                                     logic last);
      response_type r;
      logic [TURN_W-1:0] turn;
      longint s, c, sw, cw, nr, ni, dr, di;
      bit [63:0] den;
      bit sat_r, sat_i;
      int ord;
      turn = {ph, {(TURN_W-PHASE_WIDTH){1'b0}}};
      s = longint'((quarter_sine(64'(turn[29:0])) + 32) >> 6);
      c = longint'((quarter_sine(64'(ONE_Q30) - 64'(turn[29:0])) + 32) >> 6);
      case (turn[31:30])
         2'd0: begin sw = s; cw = c; end
         2'd1: begin sw = c; cw = -s; end
         2'd2: begin sw = -s; cw = -c; end
         default: begin sw = -c; cw = s; end
      endcase
      ord = (order > MAX_ORDER) ? MAX_ORDER : int'(order);
      horner_eval(0, ord, cw, -sw, nr, ni);
      horner_eval(1, ord, cw, -sw, dr, di);
      den = 64'(dr * dr) + 64'(di * di);
      r.last = last;
      r.re = 0;
      r.im = 0;
      r.st = STAT_OK;
      if (den == 0) begin
         r.st = STAT_DEN_ZERO;
      end else begin
         sat_r = divide_q23(nr * dr + ni * di, den, r.re);
         sat_i = divide_q23(ni * dr - nr * di, den, r.im);
         if (sat_r || sat_i) r.st = STAT_SAT;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      response_type exp_r;
      if (reset) begin
         foreach (num_store[i]) begin
            num_store[i] = 0;
            den_store[i] = 0;
         end
         order = '0;
         response_q.delete();
         errors = 0;
      end else begin
         if (csr_we) order = csr_wdata;
         if (req.valid && req.ready) begin
            if (req.coef_index <= MAX_ORDER && req.operation == OP_WR_NUM)
               num_store[req.coef_index] = longint'(req.coef_value);
            else if (req.coef_index <= MAX_ORDER && req.operation == OP_WR_DEN)
               den_store[req.coef_index] = longint'(req.coef_value);
            else if (req.operation == OP_EVAL)
               response_q.push_back(predict_response(req.phase, req.last_point));
         end
         if (rsp.valid && rsp.ready) begin
            if (response_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected response beat at %0t", $realtime);
            end else begin
               exp_r = response_q.pop_front();
               if (rsp.real_part !== exp_r.re || rsp.imag_part !== exp_r.im ||
                   rsp.status !== exp_r.st || rsp.is_last !== exp_r.last) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp re=%0d im=%0d st=%0d last=%0b, got re=%0d im=%0d st=%0d last=%0b",
                              exp_r.re, exp_r.im, exp_r.st, exp_r.last, rsp.real_part,
                              rsp.imag_part, rsp.status, rsp.is_last);
               end
            end
         end
      end
   end

endmodule

// File: tb/iir_frequency_response_tb.sv
// Testbench top: stimulus, idling control and verdict for the frequency response block.
`timescale 1ns / 1ps
module iir_frequency_response_tb;
   import ifr_pkg::*;

   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam int         CYCLE_LIMIT = 1000000;
   localparam int         SETTLE      = 120;   // beyond the worst evaluate latency
   localparam int         HOLD_CYCLES = 1500;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [ORD_W-1:0] csr_wdata;
   int               errors;
   int               pending;
   int               idle_pct;
   int               stall_pct;
   int               cycles;
   logic             hold_req;
   logic             hold_off;

   ifr_req_if req();
   ifr_rsp_if rsp();

   iir_frequency_response u_dut (
      .clock(clock), .reset(reset), .req_if(req), .rsp_if(rsp),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   iir_frequency_response_chk u_chk (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr_we(csr_we),
      .csr_wdata(csr_wdata), .errors(errors), .pending(pending)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Hard stop: a stuck handshake must not hang the run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Long receiver hold-off: count cycles here so the sender keeps offering beats
   // and the block backs up into its input.
   initial begin
      hold_off = 1'b0;
      wait (hold_req);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Drive response ready; stall at the phase's rate, or hold it low while held off.
   always @(posedge clock) begin
      if (reset)
         rsp.ready <= 1'b0;
      else
         rsp.ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
   end

   // Offer one beat and hold it until accepted. Valid stays high across back-to-back
   // beats; drop it only for an idle gap.
   task automatic send_beat(logic [1:0] op, logic [3:0] idx, logic [15:0] value,
                            logic [15:0] ph, logic last);
      if ($urandom_range(0, 99) < idle_pct) begin
         req.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      req.valid      <= 1'b1;
      req.operation  <= op;
      req.coef_index <= idx;
      req.coef_value <= value;
      req.phase      <= ph;
      req.last_point <= last;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic write_coef(logic [1:0] op, logic [3:0] idx, logic [15:0] value);
      send_beat(op, idx, value, 16'($urandom), 1'($urandom));
   endtask

   task automatic evaluate(logic [15:0] ph, logic last);
      send_beat(OP_EVAL, 4'($urandom), 16'($urandom), ph, last);
   endtask

   // Drain all responses, then let the block settle before touching the register.
   task automatic drain_and_settle();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_order(logic [ORD_W-1:0] ord);
      csr_we    <= 1'b1;
      csr_wdata <= ord;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly small coefficients keep the sweep in range; a share of full-scale
   // values pushes toward saturation.
   function automatic logic [15:0] pick_coef();
      if ($urandom_range(0, 3) == 0) return 16'($urandom);
      return 16'($signed($urandom_range(0, 8191)) - 4096);
   endfunction

   // One well-formed sweep: load both polynomials up to the order, then a run of
   // frequency points closed by a last-point beat.
   task automatic run_sweep(int ord, inout int count);
      int npts;
      for (int k = 0; k <= ord; k++) begin
         write_coef(OP_WR_NUM, 4'(k), pick_coef());
         write_coef(OP_WR_DEN, 4'(k), ($urandom_range(0, 9) == 0) ? 16'd0 : pick_coef());
         count += 2;
      end
      npts = $urandom_range(1, 6);
      for (int p = 0; p < npts; p++) begin
         evaluate(16'($urandom), p == npts - 1);
         count++;
      end
   endtask

   // Noise: unused operation, out-of-range index, lone points.
   task automatic noise_beat();
      case ($urandom_range(0, 2))
         0: send_beat(OP_UNUSED, 4'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
         1: write_coef(1'($urandom) ? OP_WR_DEN : OP_WR_NUM, 4'($urandom_range(9, 15)),
                       16'($urandom));
         default: evaluate(16'($urandom), 1'($urandom));
      endcase
   endtask

   task automatic random_phase(int idle, int stall, logic [ORD_W-1:0] ord, int target);
      int count;
      int eff;
      count = 0;
      idle_pct  = idle;
      stall_pct = stall;
      set_order(ord);
      eff = (ord > MAX_ORDER) ? MAX_ORDER : int'(ord);
      while (count < target) begin
         if ($urandom_range(0, 9) == 0) begin
            noise_beat();
            count++;
         end else begin
            run_sweep($urandom_range(0, eff), count);
         end
      end
      drain_and_settle();
   endtask

   initial begin
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      hold_req   = 1'b0;
      cycles     = 0;
      idle_pct   = 0;
      stall_pct  = 0;
      rsp.ready  = 1'b0;
      req.valid  = 1'b0;
      req.operation  = OP_WR_NUM;
      req.coef_index = '0;
      req.coef_value = '0;
      req.phase      = '0;
      req.last_point = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty stores give a zero denominator at order zero.
      evaluate(16'h0000, 1'b0);
      send_beat(OP_UNUSED, 4'd0, 16'h1234, 16'h0, 1'b0);
      write_coef(OP_WR_NUM, 4'd9, 16'h7fff);
      write_coef(OP_WR_DEN, 4'd15, 16'h7fff);
      evaluate(16'hffff, 1'b1);
      // Full-scale numerator over a tiny denominator saturates.
      write_coef(OP_WR_NUM, 4'd0, 16'h7fff);
      write_coef(OP_WR_DEN, 4'd0, 16'h0001);
      evaluate(16'h4000, 1'b0);
      write_coef(OP_WR_NUM, 4'd0, 16'h8000);
      evaluate(16'h8000, 1'b0);
      drain_and_settle();

      // Top order with extreme coefficients at the quadrant edges.
      set_order(4'd8);
      write_coef(OP_WR_NUM, 4'd8, 16'h8000);
      write_coef(OP_WR_DEN, 4'd8, 16'h7fff);
      write_coef(OP_WR_DEN, 4'd0, 16'h2000);
      write_coef(OP_WR_NUM, 4'd4, 16'h2000);
      evaluate(16'h0000, 1'b0);
      evaluate(16'h4000, 1'b0);
      evaluate(16'h8000, 1'b0);
      evaluate(16'hc000, 1'b0);
      evaluate(16'h3fff, 1'b1);
      drain_and_settle();
      // An order above the store depth clamps to the top order.
      set_order(4'd15);
      evaluate(16'h2000, 1'b1);
      evaluate(16'hffff, 1'b0);
      drain_and_settle();

      // Random phases: no idling, sender idle (with the long hold-off), receiver
      // stall, then both.
      random_phase(0, 0, 4'd8, 230);
      hold_req <= 1'b1;
      random_phase(49, 0, 4'd0, 230);
      random_phase(0, 49, 4'd15, 230);
      random_phase(20, 20, 4'($urandom_range(1, 7)), 230);

      if (errors == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
